// ===== rtl/pcx_rle_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// PCX RLE encoder assertion macros
// Shared property shorthands for the checker of the encoder ports.
// ---------------------------------------------------------------------------
`ifndef PCX_RLE_ENCODER_MACROS_SVH
`define PCX_RLE_ENCODER_MACROS_SVH

// same-cycle implication, masked while reset is high
`define PCX_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcx_rle_encoder: same-cycle check failed");

// next-cycle implication, masked while reset is high
`define PCX_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcx_rle_encoder: next-cycle check failed");

// next-cycle implication that also holds across reset
`define PCX_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pcx_rle_encoder: reset check failed");

`endif

// ===== rtl/pcx_pkg.sv =====
// ---------------------------------------------------------------------------
// PCX RLE encoder package
// Constants, the burst descriptor type and helpers that build bursts.
// ---------------------------------------------------------------------------
package pcx_pkg;

   // coding constants
   localparam logic [7:0] HighValue = 8'd192;
   localparam logic [7:0] CountMark = 8'hC0;
   localparam logic [7:0] HighPair  = 8'hC1;
   localparam logic [5:0] RunLimit  = 6'd63;

   // longest burst one pixel can cause: flush of three plus a high pair
   localparam int MaxBytes   = 5;
   localparam int CntW       = 3;
   localparam int QueueDepth = 4;
   localparam int PtrW       = 2;
   localparam int FillW      = 3;

   // bytes caused by one pixel, oldest in entry zero
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CntW-1:0]          count;
      logic                     fin;
   } burst_type;

   // append one byte to a burst
   function automatic burst_type push_byte(burst_type b, logic [7:0] x);
      burst_type r;
      r = b;
      r.bytes[b.count] = x;
      r.count = b.count + CntW'(1);
      return r;
   endfunction

   // append the bytes that close a run of cnt pixels of val
   function automatic burst_type flush_run(burst_type b, logic [5:0] cnt, logic [7:0] val);
      burst_type r;
      r = b;
      if (cnt >= 6'd2) begin
         r = push_byte(r, CountMark | {2'b00, cnt - 6'd1});
         r = push_byte(r, val);
      end
      if (cnt != 6'd0) begin
         r = push_byte(r, val);
      end
      return r;
   endfunction

endpackage

// ===== rtl/pcx_rle_encoder.sv =====
// ---------------------------------------------------------------------------
// PCX RLE encoder
// Run-length codes a stream of 8-bit pixels into the PCX byte stream.
// ---------------------------------------------------------------------------
//   channel | ports                                          | moves
//   --------+------------------------------------------------+----------------
//   req     | req_valid/ready, req_pixel, req_final_pixel    | one pixel
//   rsp     | rsp_valid/ready, rsp_code_byte,                | one coded byte
//           | rsp_last_of_burst, rsp_end_of_image            |
//
// A pixel is taken every cycle while the four-entry burst queue has room.
// Each pixel yields zero to five bytes; the back end sends one byte per
// cycle while rsp_ready is high, so the sustained rate is set by the back end's byte output.
// A stalled response fills the queue and then holds req_ready low.
// Synchronous reset discards any open run and empties the queue.
// ---------------------------------------------------------------------------
module pcx_rle_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel,
   input  logic       req_final_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last_of_burst,
   output logic       rsp_end_of_image
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_valid;
   pcx_pkg::burst_type push_burst;
   pcx_pkg::burst_type q_head;

   // classify pixels and track the open run
   pcx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_final_pixel (req_final_pixel),
      .q_full          (q_full),
      .push            (push),
      .push_burst      (push_burst)
   );

   // decouple front and back
   pcx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .pop        (pop),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_head     (q_head)
   );

   // serialize bursts onto the response channel
   pcx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_last_of_burst (rsp_last_of_burst),
      .rsp_end_of_image  (rsp_end_of_image)
   );

endmodule

// ===== rtl/pcx_front.sv =====
// ---------------------------------------------------------------------------
// PCX RLE front end
// Accepts pixels, tracks the open run and turns each pixel into a burst.
// ---------------------------------------------------------------------------
module pcx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_pixel,
   input  logic              req_final_pixel,
   input  logic              q_full,
   output logic              push,
   output pcx_pkg::burst_type push_burst
);

   logic [7:0]         open_value_ff, open_value_in;
   logic [5:0]         open_count_ff, open_count_in;
   logic               accept;
   logic               is_high;
   logic               run_extends;
   logic [5:0]         next_count;
   pcx_pkg::burst_type burst;

   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;
   assign is_high     = req_pixel >= pcx_pkg::HighValue;
   assign run_extends = !is_high && (open_count_ff != 6'd0) && (req_pixel == open_value_ff);
   assign next_count  = open_count_ff + 6'd1;

   // classify the pixel and build its burst
   always_comb begin
      burst         = '0;
      open_count_in = open_count_ff;
      open_value_in = open_value_ff;
      if (is_high) begin
         burst         = pcx_pkg::flush_run(burst, open_count_ff, open_value_ff);
         burst         = pcx_pkg::push_byte(burst, pcx_pkg::HighPair);
         burst         = pcx_pkg::push_byte(burst, req_pixel);
         open_count_in = 6'd0;
      end else if (run_extends) begin
         if (next_count >= pcx_pkg::RunLimit) begin
            burst = pcx_pkg::push_byte(burst,
                       pcx_pkg::CountMark | {2'b00, pcx_pkg::RunLimit - 6'd1});
            burst = pcx_pkg::push_byte(burst, open_value_ff);
            open_count_in = 6'd1;
         end else begin
            open_count_in = next_count;
         end
      end else begin
         burst         = pcx_pkg::flush_run(burst, open_count_ff, open_value_ff);
         open_value_in = req_pixel;
         open_count_in = 6'd1;
      end
      // close the image
      if (req_final_pixel) begin
         burst         = pcx_pkg::flush_run(burst, open_count_in, open_value_in);
         open_count_in = 6'd0;
         open_value_in = 8'd0;
      end
      burst.fin = req_final_pixel;
   end

   assign push       = accept && (burst.count != '0);
   assign push_burst = burst;

   // advance the run state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         open_value_ff <= 8'd0;
         open_count_ff <= 6'd0;
      end else if (accept) begin
         open_value_ff <= open_value_in;
         open_count_ff <= open_count_in;
      end
   end

endmodule

// ===== rtl/pcx_queue.sv =====
// ---------------------------------------------------------------------------
// PCX RLE burst queue
// Small FIFO of burst descriptors between the front and back ends.
// ---------------------------------------------------------------------------
module pcx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pcx_pkg::burst_type push_burst,
   input  logic               pop,
   output logic               q_full,
   output logic               q_valid,
   output pcx_pkg::burst_type q_head
);

   pcx_pkg::burst_type                 entries_ff [pcx_pkg::QueueDepth];
   logic [pcx_pkg::PtrW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [pcx_pkg::PtrW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [pcx_pkg::FillW-1:0]          fill_ff, fill_in;

   assign q_full  = fill_ff == pcx_pkg::FillW'(pcx_pkg::QueueDepth);
   assign q_valid = fill_ff != '0;
   assign q_head  = entries_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pcx_pkg::PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pcx_pkg::PtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + pcx_pkg::FillW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - pcx_pkg::FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_burst;
      end
   end

endmodule

// ===== rtl/pcx_back.sv =====
// ---------------------------------------------------------------------------
// PCX RLE back end
// Shifts each burst out one coded byte per cycle on the response channel while rsp_ready is high.
// ---------------------------------------------------------------------------
module pcx_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pcx_pkg::burst_type q_head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_code_byte,
   output logic               rsp_last_of_burst,
   output logic               rsp_end_of_image
);

   logic [pcx_pkg::MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [pcx_pkg::CntW-1:0]          left_ff, left_in;
   logic                              fin_ff, fin_in;
   logic                              take;
   logic                              on_last;

   assign on_last           = left_ff == pcx_pkg::CntW'(1);
   assign rsp_valid         = left_ff != '0;
   assign rsp_code_byte     = bytes_ff[0];
   assign rsp_last_of_burst = on_last;
   assign rsp_end_of_image  = on_last && fin_ff;
   assign take              = rsp_valid && rsp_ready;
   assign pop               = q_valid && (!rsp_valid || (take && on_last));

   // shift out delivered bytes, load the next burst
   always_comb begin
      bytes_in = bytes_ff;
      left_in  = left_ff;
      fin_in   = fin_ff;
      if (take) begin
         bytes_in = bytes_ff >> 8;
         left_in  = left_ff - pcx_pkg::CntW'(1);
      end
      if (pop) begin
         bytes_in = q_head.bytes;
         left_in  = q_head.count;
         fin_in   = q_head.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      fin_ff   <= fin_in;
   end

endmodule

// ===== rtl/pcx_rle_checker.sv =====
// ---------------------------------------------------------------------------
// PCX RLE encoder checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "pcx_rle_encoder_macros.svh"

module pcx_rle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_byte,
   input logic       rsp_last_of_burst,
   input logic       rsp_end_of_image
);

   // hold a stalled response
   `PCX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `PCX_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_code_byte))

   // image end only on the last byte of a burst
   `PCX_ASSERT_NOW(a_eoi_last, rsp_valid && rsp_end_of_image, rsp_last_of_burst)

   // drop all responses on reset
   `PCX_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_valid)

endmodule

bind pcx_rle_encoder pcx_rle_checker u_checker (.*);
